// ===== hdl/conv2d_direct_zero_pad_assert.svh =====
// Assertion macros shared by the convolution block.
`ifndef CONV2D_DIRECT_ZERO_PAD_ASSERT_SVH
`define CONV2D_DIRECT_ZERO_PAD_ASSERT_SVH

// Checked only while out of reset.
`define CDZP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define CDZP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== hdl/cdzp_pkg.sv =====
// Constants, types and microcode table of the convolution block.
package cdzp_pkg;

  localparam int MAX_ROWS        = 64;
  localparam int MAX_COLS        = 64;
  localparam int MAX_KERNEL_ROWS = 7;
  localparam int MAX_KERNEL_COLS = 7;

  localparam int CMD_W      = 2;
  localparam int IDX_W      = 6;
  localparam int VAL_W      = 16;
  localparam int PROD_W     = 2 * VAL_W;
  localparam int SUM_W      = 40;
  localparam int DIM_W      = 7;
  localparam int KDIM_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  // Signed tap position: index plus kernel half minus kernel offset.
  localparam int POS_W      = IDX_W + 2;

  localparam int IMG_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int IMG_AW    = $clog2(IMG_DEPTH);
  localparam int KRN_DEPTH = MAX_KERNEL_ROWS * MAX_KERNEL_COLS;
  localparam int KRN_AW    = $clog2(KRN_DEPTH);

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_COEF  = 2'd0,
    CMD_LOAD_PIXEL = 2'd1,
    CMD_COMPUTE    = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_ROWS  = 2'd0,
    CFG_IMAGE_COLS  = 2'd1,
    CFG_KERNEL_ROWS = 2'd2,
    CFG_KERNEL_COLS = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    COND_NONE,
    COND_NOT_START,
    COND_NOT_LAST,
    COND_OUT_BUSY
  } cond_e;

  typedef enum logic [2:0] {
    UPC_IDLE,
    UPC_INIT,
    UPC_ISSUE,
    UPC_DRAIN0,
    UPC_DRAIN1,
    UPC_EMIT
  } upc_e;

  typedef struct packed {
    logic  in_ready;
    logic  tap_rst;
    logic  tap_issue;
    logic  out_load;
    cond_e cond;
    upc_e  jump_to;
    upc_e  next_step;
  } ucode_t;

  typedef struct packed {
    logic start;
    logic last_tap;
    logic out_busy;
  } seq_stat_t;

  // Control store: jump_to when cond holds, else next_step.
  function automatic ucode_t ucode_rom(upc_e step);
    ucode_t w;
    w = '{in_ready: 1'b0, tap_rst: 1'b0, tap_issue: 1'b0, out_load: 1'b0,
          cond: COND_NONE, jump_to: UPC_IDLE, next_step: UPC_IDLE};
    case (step)
      UPC_IDLE: begin
        w.in_ready  = 1'b1;
        w.cond      = COND_NOT_START;
        w.jump_to   = UPC_IDLE;
        w.next_step = UPC_INIT;
      end
      UPC_INIT: begin
        w.tap_rst   = 1'b1;
        w.next_step = UPC_ISSUE;
      end
      UPC_ISSUE: begin
        w.tap_issue = 1'b1;
        w.cond      = COND_NOT_LAST;
        w.jump_to   = UPC_ISSUE;
        w.next_step = UPC_DRAIN0;
      end
      UPC_DRAIN0: begin
        w.next_step = UPC_DRAIN1;
      end
      UPC_DRAIN1: begin
        w.next_step = UPC_EMIT;
      end
      UPC_EMIT: begin
        w.out_load  = 1'b1;
        w.cond      = COND_OUT_BUSY;
        w.jump_to   = UPC_EMIT;
        w.next_step = UPC_IDLE;
      end
      default: begin
        w.in_ready  = 1'b1;
        w.cond      = COND_NOT_START;
        w.jump_to   = UPC_IDLE;
        w.next_step = UPC_INIT;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== hdl/cdzp_if.sv =====
// Handshake channels of the convolution block: command, result and register write.
interface cdzp_cmd_if import cdzp_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        command;
  logic [IDX_W-1:0]        row;
  logic [IDX_W-1:0]        col;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, command, row, col, value, input ready);
  modport sink   (input valid, command, row, col, value, output ready);
endinterface

interface cdzp_res_if import cdzp_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [SUM_W-1:0] sum;

  modport source (output valid, sum, input ready);
  modport sink   (input valid, sum, output ready);
endinterface

interface cdzp_cfg_if import cdzp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/cdzp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module cdzp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/cdzp_seq.sv =====
// Microcode sequencer: step counter, control store lookup and conditional jumps.
module cdzp_seq import cdzp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  seq_stat_t stat_i,
  output ucode_t    ctrl_o
);

  upc_e   upc_q, upc_d;
  ucode_t word;
  logic   cond_met;

  assign word = ucode_rom(upc_q);

  always_comb begin
    case (word.cond)
      COND_NONE:      cond_met = 1'b0;
      COND_NOT_START: cond_met = !stat_i.start;
      COND_NOT_LAST:  cond_met = !stat_i.last_tap;
      COND_OUT_BUSY:  cond_met = stat_i.out_busy;
      default:        cond_met = 1'b0;
    endcase
    upc_d = cond_met ? word.jump_to : word.next_step;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= UPC_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

  assign ctrl_o = word;

endmodule

// ===== hdl/conv2d_direct_zero_pad.sv =====
// Top level: direct 2D convolution with zero padding, microcoded tap walk.
//
//   channel  dir  payload                       taken when
//   cmd_i    in   command, row, col, value      valid && ready
//   res_o    out  sum (40 bits, 14 frac bits)   valid && ready
//   cfg_i    in   index, data                   valid && ready (always ready)
//
// Loads are taken in the idle step. A compute steps through INIT, ISSUE, DRAIN0,
// DRAIN1 and EMIT, and no command is taken until its sum has been loaded into
// the output register. The single multiplier walks one tap per cycle, and
// skipped taps are walked too. Reset clears control and the registers to 64,
// 64, 3, 3; the stores are not cleared. A stalled result holds in the output
// register while the next command is taken.
`include "conv2d_direct_zero_pad_assert.svh"

module conv2d_direct_zero_pad import cdzp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  cdzp_cmd_if.sink   cmd_i,
  cdzp_res_if.source res_o,
  cdzp_cfg_if.sink   cfg_i
);

  ucode_t    ctrl;
  seq_stat_t stat;

  logic [DIM_W-1:0]  image_rows_q, image_cols_q;
  logic [KDIM_W-1:0] kernel_rows_q, kernel_cols_q;
  logic [DIM_W-1:0]  ir_eff, ic_eff;
  logic [KDIM_W-1:0] kr_eff, kc_eff;

  logic              cmd_fire, start;
  logic [IDX_W-1:0]  r_q, c_q;
  logic [KDIM_W-1:0] l_q, k_q;
  logic [POS_W-1:0]  y_pos, x_pos;
  logic              tap_ok, last_tap;

  logic              krn_we, img_we;
  logic [KRN_AW-1:0] krn_waddr, krn_raddr;
  logic [IMG_AW-1:0] img_waddr, img_raddr;
  logic [VAL_W-1:0]  krn_rdata, img_rdata;

  logic                     v1_q, v2_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [SUM_W-1:0]  acc_q;

  logic                    res_valid_q, res_valid_d;
  logic signed [SUM_W-1:0] sum_q;
  logic                    out_busy, out_load;

  // Register file: a count of zero acts as one, above the store as the store size.
  always_comb begin
    ir_eff = (image_rows_q == '0) ? DIM_W'(1) :
             (image_rows_q > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : image_rows_q;
    ic_eff = (image_cols_q == '0) ? DIM_W'(1) :
             (image_cols_q > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : image_cols_q;
    kr_eff = (kernel_rows_q == '0) ? KDIM_W'(1) :
             (kernel_rows_q > KDIM_W'(MAX_KERNEL_ROWS)) ? KDIM_W'(MAX_KERNEL_ROWS)
                                                       : kernel_rows_q;
    kc_eff = (kernel_cols_q == '0) ? KDIM_W'(1) :
             (kernel_cols_q > KDIM_W'(MAX_KERNEL_COLS)) ? KDIM_W'(MAX_KERNEL_COLS)
                                                       : kernel_cols_q;
  end

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_rows_q  <= DIM_W'(64);
      image_cols_q  <= DIM_W'(64);
      kernel_rows_q <= KDIM_W'(3);
      kernel_cols_q <= KDIM_W'(3);
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_IMAGE_ROWS:  image_rows_q  <= cfg_i.data;
        CFG_IMAGE_COLS:  image_cols_q  <= cfg_i.data;
        CFG_KERNEL_ROWS: kernel_rows_q <= cfg_i.data[KDIM_W-1:0];
        CFG_KERNEL_COLS: kernel_cols_q <= cfg_i.data[KDIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Command side
  assign cmd_i.ready = ctrl.in_ready;
  assign cmd_fire    = cmd_i.valid && cmd_i.ready;
  assign start       = cmd_fire && (cmd_i.command == CMD_COMPUTE);

  assign krn_we = cmd_fire && (cmd_i.command == CMD_LOAD_COEF) &&
                  (cmd_i.row < MAX_KERNEL_ROWS) && (cmd_i.col < MAX_KERNEL_COLS);
  assign img_we = cmd_fire && (cmd_i.command == CMD_LOAD_PIXEL) &&
                  (cmd_i.row < MAX_ROWS) && (cmd_i.col < MAX_COLS);
  assign krn_waddr = KRN_AW'(cmd_i.row * MAX_KERNEL_COLS + cmd_i.col);
  assign img_waddr = IMG_AW'(cmd_i.row * MAX_COLS + cmd_i.col);

  always_ff @(posedge clk_i) begin
    if (start) begin
      r_q <= cmd_i.row;
      c_q <= cmd_i.col;
    end
  end

  // Tap walk: image position of tap (l, k), kept only inside the image.
  always_comb begin
    y_pos  = POS_W'(r_q) - POS_W'(l_q) + POS_W'(kr_eff >> 1);
    x_pos  = POS_W'(c_q) - POS_W'(k_q) + POS_W'(kc_eff >> 1);
    tap_ok = !y_pos[POS_W-1] && (y_pos[POS_W-2:0] < ir_eff) &&
             !x_pos[POS_W-1] && (x_pos[POS_W-2:0] < ic_eff);
    last_tap = (l_q == kr_eff - KDIM_W'(1)) && (k_q == kc_eff - KDIM_W'(1));
  end

  assign img_raddr = IMG_AW'(y_pos[POS_W-2:0] * MAX_COLS + x_pos[POS_W-2:0]);
  assign krn_raddr = KRN_AW'(l_q * MAX_KERNEL_COLS + k_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l_q <= '0;
      k_q <= '0;
    end else if (ctrl.tap_rst) begin
      l_q <= '0;
      k_q <= '0;
    end else if (ctrl.tap_issue) begin
      if (k_q == kc_eff - KDIM_W'(1)) begin
        k_q <= '0;
        l_q <= l_q + KDIM_W'(1);
      end else begin
        k_q <= k_q + KDIM_W'(1);
      end
    end
  end

  cdzp_ram #(.WIDTH(VAL_W), .DEPTH(KRN_DEPTH)) u_krn_ram (
    .clk_i   (clk_i),
    .we_i    (krn_we),
    .waddr_i (krn_waddr),
    .wdata_i (cmd_i.value),
    .raddr_i (krn_raddr),
    .rdata_o (krn_rdata)
  );

  cdzp_ram #(.WIDTH(VAL_W), .DEPTH(IMG_DEPTH)) u_img_ram (
    .clk_i   (clk_i),
    .we_i    (img_we),
    .waddr_i (img_waddr),
    .wdata_i (cmd_i.value),
    .raddr_i (img_raddr),
    .rdata_o (img_rdata)
  );

  // Read, multiply, accumulate: one stage each.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= ctrl.tap_issue && tap_ok;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= $signed(img_rdata) * $signed(krn_rdata);
    if (ctrl.tap_rst) begin
      acc_q <= '0;
    end else if (v2_q) begin
      acc_q <= acc_q + SUM_W'(prod_q);
    end
  end

  // Result register
  assign out_busy = res_valid_q && !res_o.ready;
  assign out_load = ctrl.out_load && !out_busy;

  always_comb begin
    res_valid_d = res_valid_q;
    if (out_load) begin
      res_valid_d = 1'b1;
    end else if (res_o.ready) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      sum_q <= acc_q;
    end
  end

  assign res_o.valid = res_valid_q;
  assign res_o.sum   = sum_q;

  assign stat.start    = start;
  assign stat.last_tap = last_tap;
  assign stat.out_busy = out_busy;

  cdzp_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  `CDZP_ASSERT(a_drained_when_ready, ctrl.in_ready |-> (!v1_q && !v2_q), "pipeline busy while taking an item")
  `CDZP_ASSERT(a_start_inits, start |=> ctrl.tap_rst, "compute not followed by tap init")
  `CDZP_ASSERT(a_valid_from_load, $rose(res_valid_q) |-> $past(out_load), "result valid without load")
  `CDZP_ASSERT_ALWAYS(a_reset_no_result, !rst_ni |-> !res_valid_q, "result valid in reset")

endmodule
